/* rtl/stereo_nested_allpass_reverb_unit_defines.svh */
// Assertion macros for the stereo nested allpass reverb unit.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef STEREO_NESTED_ALLPASS_REVERB_UNIT_DEFINES_SVH
`define STEREO_NESTED_ALLPASS_REVERB_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SNAR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define SNAR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SNAR_ASSERT_IMP(lbl, ante, cons)
`define SNAR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/snar_pkg.sv */
// Shared types, constants and helper functions for the nested allpass reverb.
// No dependencies.
package snar_pkg;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 17;
  localparam int COEFF_W  = 16;
  localparam int STORE_AW = 14;
  localparam int POS_W    = 12;
  localparam int MAX_LINE = 4096;

  localparam int DEF_OUTER_A_LENGTH = 1680;
  localparam int DEF_INNER_A_LENGTH = 1056;
  localparam int DEF_INNER_B_LENGTH = 398;
  localparam int DEF_OUTER_B_LENGTH = 3168;
  localparam int DEF_INNER_C_LENGTH = 1440;
  localparam int DEF_STEREO_SPREAD  = 50;

  localparam logic [GAIN_W-1:0] G_OUTER_A = 17'd19661;
  localparam logic [GAIN_W-1:0] G_INNER_A = 17'd26214;
  localparam logic [GAIN_W-1:0] G_INNER_B = 17'd39322;
  localparam logic [GAIN_W-1:0] G_OUTER_B = 17'd6554;
  localparam logic [GAIN_W-1:0] G_INNER_C = 17'd26214;

  localparam logic [GAIN_W-1:0]  RST_DRY      = 17'd65536;
  localparam logic [GAIN_W-1:0]  RST_WET      = 17'd32768;
  localparam logic [GAIN_W-1:0]  RST_FEEDBACK = 17'd32768;
  localparam logic [COEFF_W-1:0] RST_LOWPASS  = 16'd37828;

  typedef enum logic [1:0] {
    CFG_DRY      = 2'd0,
    CFG_WET      = 2'd1,
    CFG_FEEDBACK = 2'd2,
    CFG_LOWPASS  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  dry;
    logic [GAIN_W-1:0]  wet;
    logic [GAIN_W-1:0]  feedback;
    logic [COEFF_W-1:0] lowpass;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_status_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_MFB, ST_IN, ST_A0, ST_A1, ST_RD, ST_NRD, ST_NY, ST_NW,
    ST_OW, ST_OR, ST_OD, ST_A3, ST_A4, ST_LP, ST_DRY, ST_WET, ST_DONE
  } lane_state_t;

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [27:0] v);
    if (v > 28'sd8388607) return 24'sd8388607;
    else if (v < -28'sd8388608) return -24'sd8388608;
    else return v[SAMPLE_W-1:0];
  endfunction

  function automatic int line_len(input int k, input int oa, input int ia, input int ib,
                                  input int ob, input int ic, input int sp);
    int s;
    int len;
    s = (k >= 5) ? sp : 0;
    case (k % 5)
      0: len = oa + s;
      1: len = ia - s;
      2: len = ib + s;
      3: len = ob - s;
      default: len = ic + s;
    endcase
    if (len < 1) len = 1;
    if (len > MAX_LINE) len = MAX_LINE;
    return len;
  endfunction

  function automatic int line_base(input int k, input int oa, input int ia, input int ib,
                                   input int ob, input int ic, input int sp);
    int b;
    b = 0;
    for (int i = 0; i < k; i++) b += line_len(i, oa, ia, ib, ob, ic, sp);
    return b;
  endfunction

endpackage

/* rtl/snar_if.sv */
// Valid/ready channel interfaces for sample pairs in and result pairs out.
// Depends on snar_pkg.
interface snar_in_if import snar_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  modport source(output valid, output left_sample, output right_sample, input ready);
  modport sink(input valid, input left_sample, input right_sample, output ready);
endinterface

interface snar_out_if import snar_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_result;
  logic signed [SAMPLE_W-1:0] right_result;
  modport source(output valid, output left_result, output right_result, input ready);
  modport sink(input valid, input left_result, input right_result, output ready);
endinterface

/* rtl/snar_lane.sv */
// One channel of the reverb: sequencer, shared multiplier and delay memory.
// Depends on snar_pkg.
module snar_lane import snar_pkg::*; #(
  parameter int LANE           = 0,
  parameter int OUTER_A_LENGTH = DEF_OUTER_A_LENGTH,
  parameter int INNER_A_LENGTH = DEF_INNER_A_LENGTH,
  parameter int INNER_B_LENGTH = DEF_INNER_B_LENGTH,
  parameter int OUTER_B_LENGTH = DEF_OUTER_B_LENGTH,
  parameter int INNER_C_LENGTH = DEF_INNER_C_LENGTH,
  parameter int STEREO_SPREAD  = DEF_STEREO_SPREAD
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_t                       cfg,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       ack,
  output lane_status_t               status,
  output logic signed [SAMPLE_W-1:0] result
);

  localparam logic [POS_W:0] LEN_V [5] = '{
    13'(line_len(LANE*5+0, OUTER_A_LENGTH, INNER_A_LENGTH, INNER_B_LENGTH,
                 OUTER_B_LENGTH, INNER_C_LENGTH, STEREO_SPREAD)),
    13'(line_len(LANE*5+1, OUTER_A_LENGTH, INNER_A_LENGTH, INNER_B_LENGTH,
                 OUTER_B_LENGTH, INNER_C_LENGTH, STEREO_SPREAD)),
    13'(line_len(LANE*5+2, OUTER_A_LENGTH, INNER_A_LENGTH, INNER_B_LENGTH,
                 OUTER_B_LENGTH, INNER_C_LENGTH, STEREO_SPREAD)),
    13'(line_len(LANE*5+3, OUTER_A_LENGTH, INNER_A_LENGTH, INNER_B_LENGTH,
                 OUTER_B_LENGTH, INNER_C_LENGTH, STEREO_SPREAD)),
    13'(line_len(LANE*5+4, OUTER_A_LENGTH, INNER_A_LENGTH, INNER_B_LENGTH,
                 OUTER_B_LENGTH, INNER_C_LENGTH, STEREO_SPREAD))
  };
  localparam logic [STORE_AW-1:0] BASE_V [5] = '{
    14'(line_base(LANE*5+0, OUTER_A_LENGTH, INNER_A_LENGTH, INNER_B_LENGTH,
                  OUTER_B_LENGTH, INNER_C_LENGTH, STEREO_SPREAD)),
    14'(line_base(LANE*5+1, OUTER_A_LENGTH, INNER_A_LENGTH, INNER_B_LENGTH,
                  OUTER_B_LENGTH, INNER_C_LENGTH, STEREO_SPREAD)),
    14'(line_base(LANE*5+2, OUTER_A_LENGTH, INNER_A_LENGTH, INNER_B_LENGTH,
                  OUTER_B_LENGTH, INNER_C_LENGTH, STEREO_SPREAD)),
    14'(line_base(LANE*5+3, OUTER_A_LENGTH, INNER_A_LENGTH, INNER_B_LENGTH,
                  OUTER_B_LENGTH, INNER_C_LENGTH, STEREO_SPREAD)),
    14'(line_base(LANE*5+4, OUTER_A_LENGTH, INNER_A_LENGTH, INNER_B_LENGTH,
                  OUTER_B_LENGTH, INNER_C_LENGTH, STEREO_SPREAD))
  };

  localparam logic [2:0] LN_OUTER_A = 3'd0;
  localparam logic [2:0] LN_INNER_A = 3'd1;
  localparam logic [2:0] LN_INNER_B = 3'd2;
  localparam logic [2:0] LN_OUTER_B = 3'd3;
  localparam logic [2:0] LN_INNER_C = 3'd4;

  lane_state_t state_r, state_nxt;
  logic [2:0]  line_r, line_nxt;
  logic [STORE_AW-1:0] clr_r;
  logic [POS_W-1:0]    pos_r [5];

  logic signed [SAMPLE_W-1:0] x_r, in_r, a0_r, a3_r, v_r, y_r, lp_r, tapa_r, tapb_r, res_r;
  logic signed [26:0] dry_r;
  logic signed [42:0] prod_r;
  logic signed [26:0] mq;
  logic signed [24:0] mul_a;
  logic [GAIN_W-1:0]  mul_g;
  logic [GAIN_W-1:0]  g_line;

  logic [SAMPLE_W-1:0] mem_q [1 << STORE_AW];
  logic [SAMPLE_W-1:0] rdata_r;
  logic                mem_we, mem_re;
  logic [STORE_AW-1:0] mem_a, line_addr;
  logic [SAMPLE_W-1:0] mem_wd;

  logic signed [SAMPLE_W-1:0] in_v, a0_v, a1_v, y_v, a3_v, a4_v, wr_v, lp_v, wet_v, res_v;
  logic signed [25:0] wet_sum;

  assign mq        = 27'((prod_r + 43'sd32768) >>> 16);
  assign line_addr = BASE_V[line_r] + {2'b00, pos_r[line_r]};
  assign g_line    = (line_r == LN_INNER_B) ? G_INNER_B :
                     (line_r == LN_INNER_C) ? G_INNER_C : G_INNER_A;

  assign in_v    = sat24(28'(x_r) + 28'(mq));
  assign a0_v    = sat24(28'(tapa_r) - 28'(mq));
  assign a1_v    = sat24(28'(in_r) + 28'(mq));
  assign y_v     = sat24(28'(signed'(rdata_r)) - 28'(mq));
  assign wr_v    = sat24(28'(v_r) + 28'(mq));
  assign a3_v    = sat24(28'(tapb_r) - 28'(mq));
  assign a4_v    = sat24(28'(a0_r) + 28'(mq));
  assign lp_v    = sat24(28'(a3_r) + 28'(mq));
  assign wet_sum = 26'(a0_r) + 26'(a3_r) + 26'sd1;
  assign wet_v   = sat24(28'(wet_sum >>> 1));
  assign res_v   = sat24(28'(dry_r) + 28'(mq));

  always_comb begin
    state_nxt = state_r;
    line_nxt  = line_r;
    mul_a     = '0;
    mul_g     = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_a     = line_addr;
    mem_wd    = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_a  = clr_r;
        if (&clr_r) state_nxt = ST_IDLE;
      end
      ST_IDLE: if (start) state_nxt = ST_MFB;
      ST_MFB: begin
        mul_a = 25'(lp_r); mul_g = cfg.feedback; state_nxt = ST_IN;
      end
      ST_IN: begin
        mul_a = 25'(in_v); mul_g = G_OUTER_A; state_nxt = ST_A0;
      end
      ST_A0: begin
        mul_a = 25'(a0_v); mul_g = G_OUTER_A; state_nxt = ST_A1;
      end
      ST_A1: begin
        line_nxt = LN_INNER_A; state_nxt = ST_RD;
      end
      ST_RD: begin
        mem_re = 1'b1; state_nxt = ST_NRD;
      end
      ST_NRD: begin
        mul_a = 25'(v_r); mul_g = g_line; state_nxt = ST_NY;
      end
      ST_NY: begin
        mul_a = 25'(y_v); mul_g = g_line; state_nxt = ST_NW;
      end
      ST_NW: begin
        mem_we = 1'b1;
        mem_wd = wr_v;
        if (line_r == LN_INNER_A) begin
          line_nxt = LN_INNER_B; state_nxt = ST_RD;
        end else if (line_r == LN_INNER_B) begin
          line_nxt = LN_OUTER_A; state_nxt = ST_OW;
        end else begin
          line_nxt = LN_OUTER_B; state_nxt = ST_OW;
        end
      end
      ST_OW: begin
        mem_we = 1'b1; mem_wd = v_r; state_nxt = ST_OR;
      end
      ST_OR: begin
        mem_re = 1'b1; state_nxt = ST_OD;
      end
      ST_OD: begin
        if (line_r == LN_OUTER_A) begin
          mul_a = 25'(a0_r); mul_g = G_OUTER_B; state_nxt = ST_A3;
        end else begin
          mul_a = 25'(lp_r) - 25'(a3_r); mul_g = {1'b0, cfg.lowpass}; state_nxt = ST_LP;
        end
      end
      ST_A3: begin
        mul_a = 25'(a3_v); mul_g = G_OUTER_B; state_nxt = ST_A4;
      end
      ST_A4: begin
        line_nxt = LN_INNER_C; state_nxt = ST_RD;
      end
      ST_LP: begin
        mul_a = 25'(x_r); mul_g = cfg.dry; state_nxt = ST_DRY;
      end
      ST_DRY: begin
        mul_a = 25'(wet_v); mul_g = cfg.wet; state_nxt = ST_WET;
      end
      ST_WET: state_nxt = ST_DONE;
      ST_DONE: if (ack) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      line_r  <= LN_OUTER_A;
      clr_r   <= '0;
      for (int i = 0; i < 5; i++) pos_r[i] <= '0;
      tapa_r  <= '0;
      tapb_r  <= '0;
      lp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      line_r  <= line_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == ST_NW || state_r == ST_OW) begin
        if (13'(pos_r[line_r]) + 13'd1 >= LEN_V[line_r]) pos_r[line_r] <= '0;
        else pos_r[line_r] <= pos_r[line_r] + 1'b1;
      end
      if (state_r == ST_OD) begin
        if (line_r == LN_OUTER_A) tapa_r <= rdata_r;
        else tapb_r <= rdata_r;
      end
      if (state_r == ST_LP) lp_r <= lp_v;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * $signed({1'b0, mul_g});
    case (state_r)
      ST_IDLE: x_r <= sample_in;
      ST_IN:   in_r <= in_v;
      ST_A0:   a0_r <= a0_v;
      ST_A1:   v_r <= a1_v;
      ST_NY:   y_r <= y_v;
      ST_NW:   v_r <= y_r;
      ST_A3:   a3_r <= a3_v;
      ST_A4:   v_r <= a4_v;
      ST_DRY:  dry_r <= mq;
      ST_WET:  res_r <= res_v;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_q[mem_a] <= mem_wd;
    if (mem_re) rdata_r <= mem_q[mem_a];
  end

  assign status.idle = (state_r == ST_IDLE);
  assign status.done = (state_r == ST_DONE);
  assign result      = res_r;

endmodule

/* rtl/stereo_nested_allpass_reverb_unit.sv */
// Stereo nested allpass reverb, top level: config registers, two lanes, output register.
// Depends on snar_pkg, snar_if, snar_lane and the defines header.
//
// Each accepted word (a stereo pair) is processed by two identical lanes, one per
// channel, running side by side; each lane steps through its reverb with one shared
// 25x18 multiplier and one single-port delay memory. The next pair is accepted only
// after both lanes have handed their results to the output register, which waits
// for out_ch.ready while it still holds a result, so the unit works on one word at a
// time. After reset both lane memories are cleared, one entry per cycle, all 16384
// entries, before the first word is taken; configuration writes are taken throughout.
`include "stereo_nested_allpass_reverb_unit_defines.svh"
module stereo_nested_allpass_reverb_unit import snar_pkg::*; #(
  parameter int OUTER_A_LENGTH = DEF_OUTER_A_LENGTH,
  parameter int INNER_A_LENGTH = DEF_INNER_A_LENGTH,
  parameter int INNER_B_LENGTH = DEF_INNER_B_LENGTH,
  parameter int OUTER_B_LENGTH = DEF_OUTER_B_LENGTH,
  parameter int INNER_C_LENGTH = DEF_INNER_C_LENGTH,
  parameter int STEREO_SPREAD  = DEF_STEREO_SPREAD
) (
  input  logic              clk,
  input  logic              rst_n,
  snar_in_if.sink           in_ch,
  snar_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [GAIN_W-1:0] cfg_data
);

  cfg_t         cfg_r;
  lane_status_t st [2];
  logic signed [SAMPLE_W-1:0] lane_res [2];
  logic signed [SAMPLE_W-1:0] left_r, right_r;
  logic out_valid_r;
  logic in_ready_w, start, both_done, load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dry      <= RST_DRY;
      cfg_r.wet      <= RST_WET;
      cfg_r.feedback <= RST_FEEDBACK;
      cfg_r.lowpass  <= RST_LOWPASS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DRY:      cfg_r.dry      <= cfg_data;
        CFG_WET:      cfg_r.wet      <= cfg_data;
        CFG_FEEDBACK: cfg_r.feedback <= cfg_data;
        CFG_LOWPASS:  cfg_r.lowpass  <= cfg_data[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_w  = st[0].idle && st[1].idle;
  assign in_ch.ready = in_ready_w;
  assign start       = in_ch.valid && in_ready_w;
  assign both_done   = st[0].done && st[1].done;
  assign load        = both_done && (!out_valid_r || out_ch.ready);

  snar_lane #(
    .LANE(0), .OUTER_A_LENGTH(OUTER_A_LENGTH), .INNER_A_LENGTH(INNER_A_LENGTH),
    .INNER_B_LENGTH(INNER_B_LENGTH), .OUTER_B_LENGTH(OUTER_B_LENGTH),
    .INNER_C_LENGTH(INNER_C_LENGTH), .STEREO_SPREAD(STEREO_SPREAD)
  ) u_lane_l (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .start(start),
    .sample_in(in_ch.left_sample), .ack(load), .status(st[0]), .result(lane_res[0])
  );

  snar_lane #(
    .LANE(1), .OUTER_A_LENGTH(OUTER_A_LENGTH), .INNER_A_LENGTH(INNER_A_LENGTH),
    .INNER_B_LENGTH(INNER_B_LENGTH), .OUTER_B_LENGTH(OUTER_B_LENGTH),
    .INNER_C_LENGTH(INNER_C_LENGTH), .STEREO_SPREAD(STEREO_SPREAD)
  ) u_lane_r (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .start(start),
    .sample_in(in_ch.right_sample), .ack(load), .status(st[1]), .result(lane_res[1])
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_r  <= lane_res[0];
      right_r <= lane_res[1];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.left_result  = left_r;
  assign out_ch.right_result = right_r;

  `SNAR_ASSERT_NXT(a_busy_after_accept, start, !in_ready_w)
  `SNAR_ASSERT_IMP(a_lanes_lockstep, 1'b1, st[0].done == st[1].done)
  `SNAR_ASSERT_NXT(a_load_releases, load, out_valid_r && !both_done)

endmodule

/* bench/tb_snar_if.sv */
// Timescale for the testbench of the reverb unit; this file holds no interfaces.
// The bench uses the interfaces in rtl/snar_if.sv, which sim.f compiles with the block.
`timescale 1ns / 100ps

/* bench/tb_stereo_nested_allpass_reverb_unit.sv */
// Testbench for the stereo nested allpass reverb unit: a bit-true predictor of both
// channel reverbs checks every result word. Depends on snar_pkg, snar_if and the RTL.
`timescale 1ns / 100ps
module tb_stereo_nested_allpass_reverb_unit;
  import snar_pkg::*;

  localparam int LIMIT = 2000000;
  localparam int STORE_N = 16384;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data = '0;
  int cycles = 0;
  int fails = 0;
  int send_idle = 24;
  int recv_idle = 87;
  bit hold_off = 1'b0;

  snar_in_if in_ch ();
  snar_out_if out_ch ();

  stereo_nested_allpass_reverb_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  class reverb_scoreboard;
    int store[STORE_N];
    int pos[10];
    int taps[4];
    int lp[2];
    longint dry, wet, fb, coeff;
    int left_q[$];
    int right_q[$];
    int words;

    function new();
      foreach (store[i]) store[i] = 0;
      foreach (pos[i]) pos[i] = 0;
      foreach (taps[i]) taps[i] = 0;
      lp[0] = 0;
      lp[1] = 0;
      dry = RST_DRY;
      wet = RST_WET;
      fb = RST_FEEDBACK;
      coeff = RST_LOWPASS;
      words = 0;
    endfunction

    function longint clip(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function longint rnd(longint p, int s);
      return (p + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint mul(longint x, longint g);
      return rnd(x * g, 16);
    endfunction

    function int len_of(int k);
      int s;
      int n;
      s = (k >= 5) ? DEF_STEREO_SPREAD : 0;
      case (k % 5)
        0: n = DEF_OUTER_A_LENGTH + s;
        1: n = DEF_INNER_A_LENGTH - s;
        2: n = DEF_INNER_B_LENGTH + s;
        3: n = DEF_OUTER_B_LENGTH - s;
        default: n = DEF_INNER_C_LENGTH + s;
      endcase
      if (n < 1) n = 1;
      if (n > MAX_LINE) n = MAX_LINE;
      return n;
    endfunction

    function int addr_of(int k);
      int b;
      b = 0;
      for (int i = 0; i < k; i++) b += len_of(i);
      return (b + pos[k]) % STORE_N;
    endfunction

    function void step_line(int k);
      pos[k] = (pos[k] + 1 >= len_of(k)) ? 0 : pos[k] + 1;
    endfunction

    function longint nested(int k, longint x, longint g);
      int a;
      longint y;
      a = addr_of(k);
      y = clip(store[a] - mul(x, g));
      store[a] = int'(clip(x + mul(y, g)));
      step_line(k);
      return y;
    endfunction

    function int outer(int k, longint x);
      store[addr_of(k)] = int'(x);
      step_line(k);
      return store[addr_of(k)];
    endfunction

    function int reverb(int ch, longint x);
      int b;
      longint sum_in, a0o, a1i, v, a3o, a4i, mix;
      b = ch * 5;
      sum_in = clip(x + mul(lp[ch], fb));
      a0o = clip(taps[ch*2] - mul(sum_in, G_OUTER_A));
      a1i = clip(sum_in + mul(a0o, G_OUTER_A));
      v = nested(b + 1, a1i, G_INNER_A);
      v = nested(b + 2, v, G_INNER_B);
      taps[ch*2] = outer(b, v);
      a3o = clip(taps[ch*2+1] - mul(a0o, G_OUTER_B));
      a4i = clip(a0o + mul(a3o, G_OUTER_B));
      v = nested(b + 4, a4i, G_INNER_C);
      taps[ch*2+1] = outer(b + 3, v);
      lp[ch] = int'(clip(a3o + mul(lp[ch] - a3o, coeff)));
      mix = clip(rnd(a0o + a3o, 1));
      return int'(clip(mul(x, dry) + mul(mix, wet)));
    endfunction

    function void set_reg(cfg_index_t idx, longint v);
      case (idx)
        CFG_DRY: dry = v & 17'h1FFFF;
        CFG_WET: wet = v & 17'h1FFFF;
        CFG_FEEDBACK: fb = v & 17'h1FFFF;
        CFG_LOWPASS: coeff = v & 16'hFFFF;
        default: ;
      endcase
    endfunction

    function void note_pair(logic signed [23:0] l, logic signed [23:0] r);
      left_q.push_back(reverb(0, l));
      right_q.push_back(reverb(1, r));
    endfunction

    function int check_pair(logic signed [23:0] l, logic signed [23:0] r);
      logic signed [23:0] el, er;
      words++;
      if (left_q.size() == 0) begin
        $error("result word with nothing expected: %0d %0d", l, r);
        return 1;
      end
      el = left_q.pop_front();
      er = right_q.pop_front();
      if (el !== l) $error("left_result expected %0d actual %0d", el, l);
      if (er !== r) $error("right_result expected %0d actual %0d", er, r);
      return int'(el !== l) + int'(er !== r);
    endfunction
  endclass

  reverb_scoreboard sb = new();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.left_sample = '0;
    in_ch.right_sample = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("[stereo_nested_allpass_reverb_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_pair(in_ch.left_sample, in_ch.right_sample);
    if (rst_n && out_ch.valid && out_ch.ready)
      fails += sb.check_pair(out_ch.left_result, out_ch.right_result);
  end

  always @(posedge clk) begin
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  task automatic write_reg(cfg_index_t idx, int v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[GAIN_W-1:0];
    sb.set_reg(idx, v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_pair(int l, int r);
    while ($urandom_range(99) < send_idle) begin
      @(posedge clk);
      in_ch.valid <= 1'b0;
    end
    @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.left_sample <= l[23:0];
    in_ch.right_sample <= r[23:0];
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
  endtask

  // half modest levels, the rest spread over the whole range or at full scale
  function automatic int pick_sample();
    case ($urandom_range(3))
      0: return $signed($urandom()) >>> 8;
      1: return ($urandom_range(1)) ? 8388607 : -8388608;
      default: return int'($urandom_range(200000)) - 100000;
    endcase
  endfunction

  task automatic drain();
    while (sb.left_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_pairs(int n);
    for (int i = 0; i < n; i++) send_pair(pick_sample(), pick_sample());
  endtask

  initial begin
    int edge_vals[6] = '{8388607, -8388608, 0, 1, -1, 4194304};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(CFG_FEEDBACK, 65536);
    for (int i = 0; i < 6; i++) send_pair(edge_vals[i], edge_vals[5 - i]);
    drain();
    write_reg(CFG_DRY, 0);
    write_reg(CFG_WET, 65536);
    for (int i = 0; i < 10; i++) send_pair(8388607, -8388608);
    drain();
    write_reg(CFG_DRY, 131071);
    write_reg(CFG_WET, 131071);
    write_reg(CFG_LOWPASS, 65535);
    write_reg(CFG_FEEDBACK, 131071);
    for (int i = 0; i < 8; i++) send_pair(-8388608, 8388607);
    drain();
    write_reg(CFG_DRY, RST_DRY);
    write_reg(CFG_WET, RST_WET);
    write_reg(CFG_FEEDBACK, RST_FEEDBACK);
    write_reg(CFG_LOWPASS, 0);
    random_pairs(400);
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      random_pairs(40);
    join
    drain();
    send_idle = 87;
    recv_idle = 24;
    write_reg(CFG_LOWPASS, RST_LOWPASS);
    write_reg(CFG_FEEDBACK, 0);
    write_reg(CFG_WET, $urandom_range(65536));
    random_pairs(450);
    drain();
    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_FEEDBACK, 58000);
    write_reg(CFG_DRY, $urandom_range(65536));
    random_pairs(480);
    drain();
    if (sb.left_q.size() != 0) begin
      $error("%0d result words never arrived", sb.left_q.size());
      fails++;
    end
    $display("%0d words checked across six gain settings, with long receiver hold-off",
             sb.words);
    if (fails == 0) $display("[stereo_nested_allpass_reverb_unit] OK");
    else $display("[stereo_nested_allpass_reverb_unit] ERROR");
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl
rtl/snar_pkg.sv
rtl/snar_if.sv
rtl/snar_lane.sv
rtl/stereo_nested_allpass_reverb_unit.sv
bench/tb_snar_if.sv
bench/tb_stereo_nested_allpass_reverb_unit.sv
